### rtl/attc_pkg.sv
// Shared types, constants and color palette of the ANSI text terminal controller.
package attc_pkg;

  // Result queue geometry
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  // Character codes
  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLbr   = 8'h5B;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChM     = 8'h6D;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;

  // Command codes
  localparam logic CmdDraw   = 1'b0;
  localparam logic CmdScroll = 1'b1;

  // Configuration register indexes and reset values
  localparam logic       CfgColumns    = 1'b0;
  localparam logic       CfgRows       = 1'b1;
  localparam logic [8:0] ColumnsReset  = 9'd80;
  localparam logic [8:0] RowsReset     = 9'd25;

  // SGR argument codes
  localparam logic [9:0] ArgSat    = 10'd999;
  localparam logic [9:0] SgrReset  = 10'd0;
  localparam logic [9:0] SgrForeLo = 10'd30;
  localparam logic [9:0] SgrForeHi = 10'd37;
  localparam logic [9:0] SgrBackLo = 10'd40;
  localparam logic [9:0] SgrBackHi = 10'd47;

  typedef logic [31:0] color_t;

  localparam color_t ColorBlack = 32'hFF1E1E2E;
  localparam color_t ColorWhite = 32'hFFCDD6F4;

  typedef struct packed {
    color_t fore;
    color_t back;
  } colors_t;

  typedef struct packed {
    logic [8:0] columns;
    logic [8:0] rows;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] glyph;
    color_t     fore;
    color_t     back;
    logic       last;
  } result_t;

  // Results of one byte: n is 0, 1 or 2; r0 comes first.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic color_t palette(input logic [2:0] idx);
    color_t c;
    case (idx)
      3'd0:    c = 32'hFF1E1E2E;
      3'd1:    c = 32'hFFF38BA8;
      3'd2:    c = 32'hFFA6E3A1;
      3'd3:    c = 32'hFFF9E2AF;
      3'd4:    c = 32'hFF89B4FA;
      3'd5:    c = 32'hFFCBA6F7;
      3'd6:    c = 32'hFF94E2D5;
      default: c = 32'hFFCDD6F4;
    endcase
    return c;
  endfunction

  // One SGR argument applied to the pending colors.
  function automatic colors_t apply_arg(input logic [9:0] v, input colors_t cur);
    colors_t    r;
    logic [2:0] off;
    r   = cur;
    off = '0;
    if (v == SgrReset) begin
      r.fore = ColorWhite;
      r.back = ColorBlack;
    end else if (v >= SgrForeLo && v <= SgrForeHi) begin
      off    = 3'(v - SgrForeLo);
      r.fore = palette(off);
    end else if (v >= SgrBackLo && v <= SgrBackHi) begin
      off    = 3'(v - SgrBackLo);
      r.back = palette(off);
    end
    return r;
  endfunction

endpackage

### rtl/attc_core.sv
// Terminal state and escape parser: one byte in, up to two commands out per cycle.
module attc_core #(
  parameter int MAX_ARGS = 16,
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  logic [7:0]          byte_i,
  input  attc_pkg::cfg_t      cfg_i,
  output attc_pkg::push_t     push_o
);

  localparam int ArgCntW = $clog2(MAX_ARGS);
  localparam logic [ArgCntW-1:0] ArgCntLast = ArgCntW'(MAX_ARGS - 1);
  localparam logic [8:0] MaxColsW = 9'(MAX_COLS);
  localparam logic [8:0] MaxRowsW = 9'(MAX_ROWS);

  typedef enum logic [1:0] {PhIdle, PhEsc, PhArgs, PhIgnore} phase_e;

  phase_e            phase_q, phase_d;
  logic [7:0]        col_q, col_d, row_q, row_d;
  attc_pkg::colors_t now_q, now_d, pend_q, pend_d;
  logic [ArgCntW-1:0] cnt_q, cnt_d;
  logic [9:0]        arg_q, arg_d;

  logic [8:0]  nc, nr, y;
  logic        wrap, letter, digit, at_end;
  logic [7:0]  nl_row, col_m;
  logic [13:0] arg_x;
  logic [3:0]  dig;
  attc_pkg::colors_t applied;
  attc_pkg::result_t draw_r, scroll_r;

  // clamp screen size to 1..MAX
  always_comb begin
    nc = (cfg_i.columns == 9'd0) ? 9'd1 :
         (cfg_i.columns > MaxColsW) ? MaxColsW : cfg_i.columns;
    nr = (cfg_i.rows == 9'd0) ? 9'd1 :
         (cfg_i.rows > MaxRowsW) ? MaxRowsW : cfg_i.rows;
  end

  assign y      = {1'b0, row_q} + 9'd1;
  assign wrap   = (y >= nr);
  assign nl_row = wrap ? 8'(nr - 9'd1) : y[7:0];
  assign at_end = (({1'b0, col_q} + 9'd1) >= nc);
  assign col_m  = (col_q == 8'd0) ? 8'd0 : col_q - 8'd1;

  assign letter = (byte_i >= attc_pkg::ChUpA && byte_i <= attc_pkg::ChUpZ) ||
                  (byte_i >= attc_pkg::ChLoA && byte_i <= attc_pkg::ChLoZ);
  assign digit  = (byte_i >= attc_pkg::Ch0 && byte_i <= attc_pkg::Ch9);
  assign dig    = 4'(byte_i - attc_pkg::Ch0);
  assign arg_x  = 14'({arg_q, 3'b000}) + 14'({arg_q, 1'b0}) + 14'(dig);
  assign applied = attc_pkg::apply_arg(arg_q, pend_q);

  always_comb begin
    draw_r       = '0;
    draw_r.cmd   = attc_pkg::CmdDraw;
    draw_r.col   = col_q;
    draw_r.row   = row_q;
    draw_r.glyph = byte_i;
    draw_r.fore  = now_q.fore;
    draw_r.back  = now_q.back;
    scroll_r      = '0;
    scroll_r.cmd  = attc_pkg::CmdScroll;
    scroll_r.fore = now_q.fore;
    scroll_r.back = now_q.back;
    scroll_r.last = 1'b1;
  end

  always_comb begin
    phase_d = phase_q;
    col_d   = col_q;
    row_d   = row_q;
    now_d   = now_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    arg_d   = arg_q;
    push_o  = '0;
    if (vld_i) begin
      if (byte_i == attc_pkg::ChEsc) begin
        phase_d = PhEsc;
        cnt_d   = '0;
        arg_d   = '0;
        pend_d  = now_q;
      end else begin
        case (phase_q)
          PhIdle: begin
            if (byte_i == attc_pkg::ChNl) begin
              col_d = 8'd0;
              row_d = nl_row;
              if (wrap) begin
                push_o.n  = 2'd1;
                push_o.r0 = scroll_r;
              end
            end else if (byte_i == attc_pkg::ChBs) begin
              col_d        = col_m;
              push_o.n     = 2'd1;
              push_o.r0    = draw_r;
              push_o.r0.col   = col_m;
              push_o.r0.glyph = attc_pkg::ChSpace;
              push_o.r0.last  = 1'b1;
            end else begin
              push_o.r0 = draw_r;
              if (at_end) begin
                col_d = 8'd0;
                row_d = nl_row;
                if (wrap) begin
                  push_o.n  = 2'd2;
                  push_o.r1 = scroll_r;
                end else begin
                  push_o.n       = 2'd1;
                  push_o.r0.last = 1'b1;
                end
              end else begin
                col_d          = col_q + 8'd1;
                push_o.n       = 2'd1;
                push_o.r0.last = 1'b1;
              end
            end
          end
          PhEsc: begin
            if (letter)                       phase_d = PhIdle;
            else if (byte_i == attc_pkg::ChLbr) phase_d = PhArgs;
            else                              phase_d = PhIgnore;
          end
          PhArgs: begin
            if (letter) begin
              if (byte_i == attc_pkg::ChH) begin
                col_d = 8'd0;
                row_d = 8'd0;
              end else if (byte_i == attc_pkg::ChM) begin
                pend_d = applied;
                now_d  = applied;
              end
              phase_d = PhIdle;
            end else if (byte_i == attc_pkg::ChSemi) begin
              if (cnt_q >= ArgCntLast) begin
                phase_d = PhIgnore;
              end else begin
                pend_d = applied;
                cnt_d  = cnt_q + ArgCntW'(1);
                arg_d  = '0;
              end
            end else if (digit) begin
              arg_d = (arg_x > 14'(attc_pkg::ArgSat)) ? attc_pkg::ArgSat : arg_x[9:0];
            end
          end
          PhIgnore: begin
            if (letter) phase_d = PhIdle;
          end
          default: phase_d = PhIdle;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      col_q   <= '0;
      row_q   <= '0;
      now_q   <= '{fore: attc_pkg::ColorWhite, back: attc_pkg::ColorBlack};
      pend_q  <= '{fore: attc_pkg::ColorWhite, back: attc_pkg::ColorBlack};
      cnt_q   <= '0;
      arg_q   <= '0;
    end else begin
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
      now_q   <= now_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      arg_q   <= arg_d;
    end
  end

endmodule

### rtl/attc_fifo.sv
// Result queue: up to two commands in and, while ready, one beat out per cycle.
module attc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  attc_pkg::push_t   push_i,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output attc_pkg::result_t head_o,
  output logic              room_o
);

  localparam int PtrW = attc_pkg::FifoPtrW;

  attc_pkg::result_t mem_q [attc_pkg::FifoDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              pop;

  assign m_tvalid_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];
  assign pop        = m_tvalid_o && m_tready_i;
  // room for the byte in the input register plus one more
  assign room_o     = (cnt_q <= (PtrW+1)'(attc_pkg::FifoDepth - 4));

  assign wr_d  = wr_q + PtrW'(push_i.n);
  assign rd_d  = rd_q + PtrW'(pop);
  assign cnt_d = cnt_q + (PtrW+1)'(push_i.n) - (PtrW+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_q + PtrW'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/ansi_text_terminal_controller.sv
// Top level of the ANSI text terminal controller: config, input register, core, result queue.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] char_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata[87:0] cell fields + colors,
//                                              tuser command, tlast last_of_run
//  cfg       in   cfg_we_i (no stall)          cfg_index_i, cfg_data_i
//
//  A byte is registered on accept and processed in the next cycle; its commands
//  are written into the result queue, whose head drives m_axis. One byte per cycle
//  is taken while s_axis_tready is high; a byte that draws at the last cell of the last row
//  yields two beats, so the rate there is bounded by the single output port.
//  s_axis_tready drops when the result queue has fewer than four free entries.
//  Reset (rst_ni low, asynchronous) homes the cursor, sets white on black,
//  leaves the parser idle, and loads columns=80, rows=25.
module ansi_text_terminal_controller #(
  parameter int MAX_ARGS = 16,
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  // byte input; tdata: [7:0] char_byte
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // command output; tdata: [7:0] cell_column, [15:8] cell_row, [23:16] glyph_code,
  // [55:24] fore_color, [87:56] back_color; tuser: [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  attc_pkg::cfg_t    cfg_q;
  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  attc_pkg::push_t   push;
  attc_pkg::result_t head;
  logic              room;

  assign s_axis_tready = room;

  // screen size registers; to be written by the user only while idle, not enforced here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns <= attc_pkg::ColumnsReset;
      cfg_q.rows    <= attc_pkg::RowsReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        attc_pkg::CfgColumns: cfg_q.columns <= cfg_data_i;
        attc_pkg::CfgRows:    cfg_q.rows    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register: one beat per cycle while s_axis_tready is high
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_byte_q <= s_axis_tdata;
  end

  attc_core #(
    .MAX_ARGS (MAX_ARGS),
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_vld_q),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .push_o (push)
  );

  attc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .head_o     (head),
    .room_o     (room)
  );

  assign m_axis_tdata = {head.back, head.fore, head.glyph, head.row, head.col};
  assign m_axis_tuser = head.cmd;
  assign m_axis_tlast = head.last;

endmodule

### bench/tb.sv
// Self-checking bench for the ANSI text terminal controller: byte stream in, commands checked.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Must match the DUT build below
  localparam int MaxArgs = 16;
  localparam int MaxCols = 256;
  localparam int MaxRows = 256;

  // Receiver hold-off used once to back the block up
  localparam int unsigned SqueezeCycles = 400;
  // Cycles with no beat on either side before giving up
  localparam int unsigned StallLimit = 3000;
  // Quiet cycles after the last expected command (pipeline plus margin)
  localparam int unsigned DrainCycles = 6;

  // Palette, index 7 first since packed arrays fill from the top
  localparam logic [7:0][31:0] Shades = {
    32'hFFCDD6F4, 32'hFF94E2D5, 32'hFFCBA6F7, 32'hFF89B4FA,
    32'hFFF9E2AF, 32'hFFA6E3A1, 32'hFFF38BA8, 32'hFF1E1E2E
  };

  typedef enum logic [1:0] {ParseIdle, ParseEsc, ParseArgs, ParseSkip} parse_e;

  // ---------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_index_i   = attc_pkg::CfgColumns;
  logic [8:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] char_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] cell_column, [15:8] cell_row, [23:16] glyph_code,
  // [55:24] fore_color, [87:56] back_color
  logic [87:0] m_axis_tdata;
  logic        m_axis_tuser;         // [0] command
  logic        m_axis_tlast;

  wire byte_beat = s_axis_tvalid && s_axis_tready;
  wire cmd_beat  = m_axis_tvalid && m_axis_tready;

  // ---------------------------------------------------------------------------
  // Terminal predictor state (own copy of registers and parser)
  // ---------------------------------------------------------------------------
  logic [8:0]       cfg_cols  = attc_pkg::ColumnsReset;
  logic [8:0]       cfg_rows  = attc_pkg::RowsReset;
  logic [7:0]       cur_col   = '0;
  logic [7:0]       cur_row   = '0;
  attc_pkg::color_t fore_now  = attc_pkg::ColorWhite;
  attc_pkg::color_t back_now  = attc_pkg::ColorBlack;
  attc_pkg::color_t pend_fore = attc_pkg::ColorWhite;
  attc_pkg::color_t pend_back = attc_pkg::ColorBlack;
  parse_e           parse     = ParseIdle;
  int unsigned      arg_cnt   = 0;
  int unsigned      arg_val   = 0;

  // Bytes waiting to be sent, commands waiting to come out
  logic [7:0]        byte_q [$];
  attc_pkg::result_t cmds_due [$];

  // Bench bookkeeping
  int unsigned       mismatches   = 0;
  int unsigned       gap_left     = 0;
  int unsigned       hold_left    = 0;
  int unsigned       pause        = 0;
  int unsigned       beats_seen   = 0;
  int unsigned       idle_cycles  = 0;
  bit                send_calm    = 1'b0;
  bit                recv_calm    = 1'b0;
  bit                squeeze_done = 1'b0;
  attc_pkg::result_t want;

  ansi_text_terminal_controller #(
    .MAX_ARGS(MaxArgs),
    .MAX_COLS(MaxCols),
    .MAX_ROWS(MaxRows)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Screen size as used: zero acts as one, large values cap at the maximum.
  function automatic int unsigned fit_dim(input logic [8:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic bit letter_byte(input logic [7:0] ch);
    return (ch >= attc_pkg::ChUpA && ch <= attc_pkg::ChUpZ) ||
           (ch >= attc_pkg::ChLoA && ch <= attc_pkg::ChLoZ);
  endfunction

  // One SGR argument into the colors that the open sequence will commit.
  function automatic void sgr_update(input int unsigned v);
    if (v == attc_pkg::SgrReset) begin
      pend_fore = attc_pkg::ColorWhite;
      pend_back = attc_pkg::ColorBlack;
    end else if (v >= attc_pkg::SgrForeLo && v <= attc_pkg::SgrForeHi) begin
      pend_fore = Shades[3'(v - attc_pkg::SgrForeLo)];
    end else if (v >= attc_pkg::SgrBackLo && v <= attc_pkg::SgrBackHi) begin
      pend_back = Shades[3'(v - attc_pkg::SgrBackLo)];
    end
  endfunction

  function automatic attc_pkg::result_t make_cmd(input logic cmd, input logic [7:0] col,
                                                 input logic [7:0] row,
                                                 input logic [7:0] glyph);
    attc_pkg::result_t r;
    r.cmd   = cmd;
    r.col   = col;
    r.row   = row;
    r.glyph = glyph;
    r.fore  = fore_now;
    r.back  = back_now;
    r.last  = 1'b0;
    return r;
  endfunction

  // Cursor to the start of the next line; returns 1 when the screen must scroll.
  // Clamping to the last row also pulls in a row left beyond a shrunken screen.
  function automatic bit feed_line();
    int unsigned tall;
    int unsigned y;
    tall    = fit_dim(cfg_rows, MaxRows);
    y       = int'(cur_row) + 1;
    cur_col = '0;
    if (y >= tall) begin
      cur_row = 8'(tall - 1);
      return 1'b1;
    end
    cur_row = 8'(y);
    return 1'b0;
  endfunction

  // Advance the terminal by one byte and queue the commands it produces.
  task automatic interpret_byte(input logic [7:0] ch);
    attc_pkg::result_t made [2];
    int unsigned       n;
    int unsigned       wide;
    int unsigned       k;
    n = 0;
    if (ch == attc_pkg::ChEsc) begin
      // ESC always (re)starts a sequence, pending colors from the live ones
      parse     = ParseEsc;
      arg_cnt   = 0;
      arg_val   = 0;
      pend_fore = fore_now;
      pend_back = back_now;
    end else if (parse != ParseIdle) begin
      case (parse)
        ParseEsc: begin
          if (letter_byte(ch)) parse = ParseIdle;
          else if (ch == attc_pkg::ChLbr) parse = ParseArgs;
          else parse = ParseSkip;
        end
        ParseArgs: begin
          if (letter_byte(ch)) begin
            if (ch == attc_pkg::ChH) begin
              cur_col = '0;
              cur_row = '0;
            end else if (ch == attc_pkg::ChM) begin
              sgr_update(arg_val);
              fore_now = pend_fore;
              back_now = pend_back;
            end
            parse = ParseIdle;
          end else if (ch == attc_pkg::ChSemi) begin
            // one separator too many kills the sequence
            if (arg_cnt >= MaxArgs - 1) begin
              parse = ParseSkip;
            end else begin
              sgr_update(arg_val);
              arg_cnt++;
              arg_val = 0;
            end
          end else if (ch >= attc_pkg::Ch0 && ch <= attc_pkg::Ch9) begin
            arg_val = arg_val * 10 + int'(ch - attc_pkg::Ch0);
            if (arg_val > attc_pkg::ArgSat) arg_val = 32'(attc_pkg::ArgSat);
          end
        end
        default: begin
          if (letter_byte(ch)) parse = ParseIdle;
        end
      endcase
    end else if (ch == attc_pkg::ChNl) begin
      if (feed_line()) begin
        made[n] = make_cmd(attc_pkg::CmdScroll, '0, '0, '0);
        n++;
      end
    end else if (ch == attc_pkg::ChBs) begin
      // erase even at column zero
      if (cur_col != 0) cur_col--;
      made[0] = make_cmd(attc_pkg::CmdDraw, cur_col, cur_row, attc_pkg::ChSpace);
      n = 1;
    end else begin
      wide    = fit_dim(cfg_cols, MaxCols);
      made[0] = make_cmd(attc_pkg::CmdDraw, cur_col, cur_row, ch);
      n = 1;
      if (int'(cur_col) + 1 >= wide) begin
        if (feed_line()) begin
          made[n] = make_cmd(attc_pkg::CmdScroll, '0, '0, '0);
          n++;
        end
      end else begin
        cur_col++;
      end
    end
    for (k = 0; k < n; k++) begin
      made[k].last = (k == n - 1);
      cmds_due.push_back(made[k]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned draw_pause(input bit calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Any byte that draws a glyph
  function automatic logic [7:0] any_glyph();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    if (ch == attc_pkg::ChEsc || ch == attc_pkg::ChNl || ch == attc_pkg::ChBs) begin
      ch = ch ^ 8'h40;
    end
    return ch;
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(attc_pkg::ChUpA, attc_pkg::ChUpZ));
    return 8'($urandom_range(attc_pkg::ChLoA, attc_pkg::ChLoZ));
  endfunction

  // Neither letter, digit, separator, bracket nor ESC
  function automatic logic [7:0] pick_junk();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    while (letter_byte(ch) || (ch >= attc_pkg::Ch0 && ch <= attc_pkg::Ch9) ||
           ch == attc_pkg::ChSemi || ch == attc_pkg::ChLbr || ch == attc_pkg::ChEsc) begin
      ch = 8'($urandom_range(0, 255));
    end
    return ch;
  endfunction

  // SGR argument: reset, colors, near misses, overflow, or empty (-1)
  function automatic int pick_arg();
    case ($urandom_range(0, 7))
      0:       return 0;
      1, 2:    return $urandom_range(attc_pkg::SgrForeLo, attc_pkg::SgrForeHi);
      3, 4:    return $urandom_range(attc_pkg::SgrBackLo, attc_pkg::SgrBackHi);
      5:       return $urandom_range(0, 99);
      6:       return $urandom_range(100, 99999);
      default: return -1;
    endcase
  endfunction

  task automatic push_number(input int v);
    string       s;
    int unsigned k;
    if (v < 0) return;
    s = $sformatf("%0d", v);
    for (k = 0; k < s.len(); k++) byte_q.push_back(s[k]);
  endtask

  // Random traffic: mostly text and well-formed sequences, some broken ones and noise.
  task automatic queue_traffic(input int unsigned budget);
    int unsigned goal;
    int unsigned pick;
    int unsigned reps;
    int unsigned k;
    goal = byte_q.size() + budget;
    while (byte_q.size() < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        reps = $urandom_range(1, 6);
        repeat (reps) byte_q.push_back(any_glyph());
      end else if (pick < 45) begin
        byte_q.push_back(attc_pkg::ChNl);
      end else if (pick < 52) begin
        byte_q.push_back(attc_pkg::ChBs);
      end else if (pick < 92) begin
        byte_q.push_back(attc_pkg::ChEsc);
        if (pick < 67) begin
          // color select, 1..5 arguments
          byte_q.push_back(attc_pkg::ChLbr);
          reps = $urandom_range(0, 4);
          for (k = 0; k <= reps; k++) begin
            push_number(pick_arg());
            if (k < reps) byte_q.push_back(attc_pkg::ChSemi);
          end
          byte_q.push_back(attc_pkg::ChM);
        end else if (pick < 72) begin
          // cursor home, arguments ignored
          byte_q.push_back(attc_pkg::ChLbr);
          if ($urandom_range(0, 1) == 1) begin
            push_number($urandom_range(0, 300));
            byte_q.push_back(attc_pkg::ChSemi);
            push_number($urandom_range(0, 300));
          end
          byte_q.push_back(attc_pkg::ChH);
        end else if (pick < 76) begin
          // letter right after ESC
          byte_q.push_back(pick_letter());
        end else if (pick < 80) begin
          // not a CSI: swallowed up to a letter
          byte_q.push_back(pick_junk());
          reps = $urandom_range(0, 3);
          repeat (reps) byte_q.push_back(8'($urandom_range(0, 255)));
          byte_q.push_back(pick_letter());
        end else if (pick < 84) begin
          // separator count around the argument limit
          byte_q.push_back(attc_pkg::ChLbr);
          reps = $urandom_range(MaxArgs - 2, MaxArgs + 1);
          repeat (reps) begin
            push_number(pick_arg());
            byte_q.push_back(attc_pkg::ChSemi);
          end
          push_number(pick_arg());
          byte_q.push_back(attc_pkg::ChM);
        end else if (pick < 88) begin
          // sequence cut short by a fresh ESC
          byte_q.push_back(attc_pkg::ChLbr);
          push_number(pick_arg());
          if ($urandom_range(0, 1) == 1) byte_q.push_back(attc_pkg::ChSemi);
          byte_q.push_back(attc_pkg::ChEsc);
          byte_q.push_back(attc_pkg::ChLbr);
          push_number(pick_arg());
          byte_q.push_back(attc_pkg::ChM);
        end else begin
          // stray bytes inside, random final letter
          byte_q.push_back(attc_pkg::ChLbr);
          push_number(pick_arg());
          byte_q.push_back(pick_junk());
          push_number(pick_arg());
          byte_q.push_back(pick_letter());
        end
      end else begin
        byte_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Wait until every byte went in and every command came out, then let the pipe empty.
  task automatic settle();
    while (byte_q.size() != 0 || s_axis_tvalid || cmds_due.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // New screen size, written only while the block is idle.
  task automatic reconfigure(input logic [8:0] cols, input logic [8:0] rows);
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= attc_pkg::CfgColumns;
    cfg_data_i  <= cols;
    @(posedge clk_i);
    cfg_index_i <= attc_pkg::CfgRows;
    cfg_data_i  <= rows;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_cols = cols;
    cfg_rows = rows;
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver: feeds byte_q, random gap after each beat, predicts on accept
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= 0;
    end else begin
      if (byte_beat) interpret_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          s_axis_tdata  <= byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          gap_left      <= draw_pause(send_calm);
          // occasional switch between gappy and back-to-back stretches
          if ($urandom_range(0, 39) == 0) send_calm <= !send_calm;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command monitor: checks each beat, stalls at random, one long squeeze
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
    end else begin
      if (cmd_beat) begin
        if (cmds_due.size() == 0) begin
          $error("command beat with nothing expected: cmd %0d tdata %h last %0d",
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = cmds_due.pop_front();
          check_field("command", 32'(want.cmd), 32'(m_axis_tuser));
          check_field("cell_column", 32'(want.col), 32'(m_axis_tdata[7:0]));
          check_field("cell_row", 32'(want.row), 32'(m_axis_tdata[15:8]));
          check_field("glyph_code", 32'(want.glyph), 32'(m_axis_tdata[23:16]));
          check_field("fore_color", want.fore, m_axis_tdata[55:24]);
          check_field("back_color", want.back, m_axis_tdata[87:56]);
          check_field("last_of_run", 32'(want.last), 32'(m_axis_tlast));
        end
        beats_seen <= beats_seen + 1;
        // hold off long once the sender has plenty queued, so the block backs up
        if (!squeeze_done && beats_seen >= 150 && byte_q.size() > 50) begin
          pause        = SqueezeCycles;
          squeeze_done <= 1'b1;
        end else begin
          pause = draw_pause(recv_calm);
        end
        if ($urandom_range(0, 39) == 0) recv_calm <= !recv_calm;
        hold_left     <= pause;
        m_axis_tready <= (pause == 0);
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= (hold_left == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no beat on either side for too long ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_beat || cmd_beat) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, at the reset size of 80x25:
    //  backspace at column 0, byte extremes, plain glyph, backspace, newline,
    //  fg/bg select then a glyph in the new colors, home, letter right after ESC,
    //  non-CSI junk swallowed up to a letter, empty argument resets colors.
    byte_q = '{attc_pkg::ChBs, 8'h00, 8'hFF, attc_pkg::ChUpA, attc_pkg::ChBs,
               attc_pkg::ChNl,
               attc_pkg::ChEsc, attc_pkg::ChLbr, 8'h33, 8'h31, attc_pkg::ChSemi,
               8'h34, 8'h34, attc_pkg::ChM,
               attc_pkg::ChUpZ,
               attc_pkg::ChEsc, attc_pkg::ChLbr, attc_pkg::ChH,
               attc_pkg::ChEsc, 8'h71,
               attc_pkg::ChEsc, 8'h3F, 8'h35, 8'h6B,
               attc_pkg::ChEsc, attc_pkg::ChLbr, attc_pkg::ChM};

    // Single cell: every glyph wraps and scrolls (two beats per byte)
    reconfigure(9'd1, 9'd1);
    queue_traffic(80);

    // Largest screen: walk to the last column and the last row
    reconfigure(9'd256, 9'd256);
    byte_q.push_back(attc_pkg::ChEsc);
    byte_q.push_back(attc_pkg::ChLbr);
    byte_q.push_back(attc_pkg::ChH);
    repeat (260) byte_q.push_back(any_glyph());
    repeat (258) byte_q.push_back(attc_pkg::ChNl);
    queue_traffic(60);

    // Zero acts as one; the cursor is left far outside the shrunken screen
    reconfigure(9'd0, 9'd0);
    queue_traffic(50);

    // Over-range values saturate
    reconfigure(9'd511, 9'd511);
    queue_traffic(80);

    reconfigure(9'd7, 9'd3);
    queue_traffic(80);

    repeat (3) begin
      reconfigure(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
      queue_traffic(50);
    end

    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
